### src/sit_pkg.sv
// shared types and codes for the sorted insert table
`default_nettype none

package sit_pkg;

    // key width fixed by the transaction format
    localparam int KEY_W = 32;
    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REM_MIN     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REM_MAX     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REM_AT      = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins_en;
        logic signed [KEY_W-1:0] ins_key;
    } sit_ctrl_t;

endpackage

`default_nettype wire

### src/sit_cell.sv
// one storage cell of the sorted chain
`default_nettype none

module sit_cell
    import sit_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire sit_ctrl_t          ctrl,
    input  wire                     rem_shift,
    input  wire                     left_less,
    input  wire signed [KEY_W-1:0]  left_key,
    input  wire                     left_valid,
    input  wire signed [KEY_W-1:0]  right_key,
    input  wire                     right_valid,
    output logic signed [KEY_W-1:0] key,
    output logic                    valid,
    output logic                    less,
    output logic signed [KEY_W-1:0] key_nx,
    output logic                    valid_nx
);

    logic signed [KEY_W-1:0] key_reg;
    logic                    valid_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid_next;

    assign key   = key_reg;
    assign valid = valid_reg;

    // stored key sits before the new key
    assign less = valid_reg && (key_reg < ctrl.ins_key);

    // insert moves right from the insertion point, remove pulls from the right
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.ins_en && !less)
        begin
            if (left_less)
            begin
                key_next   = ctrl.ins_key;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
        else if (rem_shift)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    assign key_nx   = key_next;
    assign valid_nx = valid_next;

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // key payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

### src/sorted_insert_table.sv
// sorted insert table: a chain of key cells kept in ascending order
// result: registered, and shown on the rsp port in the cycle after its command is accepted
// throughput: one command per cycle; every cell shifts in the same cycle
// a command is held off only while a finished result waits on rsp_stall
// reset empties the table (all cell valid flags and the count cleared)
`default_nettype none

module sorted_insert_table
    import sit_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cmd_valid,
    output logic                    cmd_stall,
    input  wire [CMD_W-1:0]         command,
    input  wire signed [KEY_W-1:0]  key_value,
    input  wire [POS_W-1:0]         position,
    output logic                    rsp_valid,
    input  wire                     rsp_stall,
    output logic signed [KEY_W-1:0] removed_key,
    output logic [POS_W-1:0]        entry_count,
    output logic signed [KEY_W-1:0] smallest_key,
    output logic signed [KEY_W-1:0] largest_key,
    output logic [ST_W-1:0]         status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                    rsp_valid_reg;
    logic signed [KEY_W-1:0] removed_reg;
    logic [POS_W-1:0]        count_out_reg;
    logic signed [KEY_W-1:0] smallest_reg;
    logic signed [KEY_W-1:0] largest_reg;
    logic [ST_W-1:0]         status_reg;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    pos_bad;
    logic [PW-1:0]           pos_ext;
    logic [PW-1:0]           cnt_ext;
    logic [PW-1:0]           pos_m1;
    logic [PW-1:0]           cnt_m1;
    logic [PW-1:0]           cnt_next_ext;
    logic [IW-1:0]           rem_idx;
    logic                    do_ins;
    logic                    do_rem;
    logic [ST_W-1:0]         status_next;
    sit_ctrl_t               ctrl;

    logic [CAPACITY-1:0]                   rem_from;
    logic [CAPACITY-1:0]                   rem_hit;
    logic [CAPACITY-1:0]                   cell_valid;
    logic [CAPACITY-1:0]                   cell_less;
    logic [CAPACITY-1:0]                   cell_valid_nx;
    logic [CAPACITY-1:0]                   cell_last_nx;
    logic signed [CAPACITY-1:0][KEY_W-1:0] cell_key;
    logic signed [CAPACITY-1:0][KEY_W-1:0] cell_key_nx;

    logic signed [KEY_W-1:0] removed_next;
    logic signed [KEY_W-1:0] largest_next;
    logic signed [KEY_W-1:0] smallest_next;

    // handshake
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    // command decode and checks
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign pos_m1  = pos_ext - PW'(1);
    assign cnt_m1  = cnt_ext - PW'(1);
    assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

    always_comb
    begin
        status_next = ST_OK;
        rem_idx     = '0;
        case (command)
            CMD_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
            end
            CMD_REM_MIN:
            begin
                if (empty)
                    status_next = ST_EMPTY;
            end
            CMD_REM_MAX:
            begin
                rem_idx = cnt_m1[IW-1:0];
                if (empty)
                    status_next = ST_EMPTY;
            end
            CMD_REM_AT:
            begin
                rem_idx = pos_m1[IW-1:0];
                if (empty)
                    status_next = ST_EMPTY;
                else if (pos_bad)
                    status_next = ST_BADPOS;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign do_ins = accept && (command == CMD_INSERT) && (status_next == ST_OK);
    assign do_rem = accept && (command != CMD_INSERT) && (status_next == ST_OK);

    assign ctrl.ins_en  = do_ins;
    assign ctrl.ins_key = key_value;

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_rem)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    l_less;
            logic signed [KEY_W-1:0] l_key;
            logic                    l_valid;
            logic signed [KEY_W-1:0] r_key;
            logic                    r_valid;

            assign rem_from[gi] = do_rem && (IW'(gi) >= rem_idx);

            if (gi == 0)
            begin : g_head
                assign l_less      = 1'b1;
                assign l_key       = key_value;
                assign l_valid     = 1'b1;
                assign rem_hit[gi] = rem_from[gi];
            end
            else
            begin : g_body
                assign l_less      = cell_less[gi-1];
                assign l_key       = cell_key[gi-1];
                assign l_valid     = cell_valid[gi-1];
                assign rem_hit[gi] = rem_from[gi] && !rem_from[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_key            = cell_key[gi];
                assign r_valid          = 1'b0;
                assign cell_last_nx[gi] = cell_valid_nx[gi];
            end
            else
            begin : g_mid
                assign r_key            = cell_key[gi+1];
                assign r_valid          = cell_valid[gi+1];
                assign cell_last_nx[gi] = cell_valid_nx[gi] && !cell_valid_nx[gi+1];
            end

            sit_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .rem_shift   (rem_from[gi]),
                .left_less   (l_less),
                .left_key    (l_key),
                .left_valid  (l_valid),
                .right_key   (r_key),
                .right_valid (r_valid),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .less        (cell_less[gi]),
                .key_nx      (cell_key_nx[gi]),
                .valid_nx    (cell_valid_nx[gi])
            );
        end
    endgenerate

    // pick the removed key and the new end keys
    always_comb
    begin
        removed_next = '0;
        largest_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rem_hit[i])
                removed_next = removed_next | cell_key[i];
            if (cell_last_nx[i])
                largest_next = largest_next | cell_key_nx[i];
        end
    end

    assign smallest_next = cell_valid_nx[0] ? cell_key_nx[0] : '0;
    assign cnt_next_ext  = PW'(count_next);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg   <= removed_next;
            count_out_reg <= cnt_next_ext[POS_W-1:0];
            smallest_reg  <= smallest_next;
            largest_reg   <= largest_next;
            status_reg    <= status_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign removed_key  = removed_reg;
    assign entry_count  = count_out_reg;
    assign smallest_key = smallest_reg;
    assign largest_key  = largest_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire
